### rtl/vpqv_pkg.sv
// Package: shared widths, constants and register indexes of the vertex projection block
`timescale 1ns / 1ps
package vpqv_pkg;
    localparam int VPQV_FRAC_BITS = 16;
    localparam int H_W            = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int CAM_REGS       = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROW0_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROW0_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROW1_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROW1_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROW2_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROW2_B = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA   = 3'd7;
endpackage

### rtl/vpqv_div.sv
// Radix-2 restoring divider: (numer << FRAC_BITS) / denom, one quotient bit per cycle
`timescale 1ns / 1ps
module vpqv_div #(
    parameter int FRAC_BITS = vpqv_pkg::VPQV_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [vpqv_pkg::H_W-1:0]        numer,
    input  logic [vpqv_pkg::H_W-1:0]        denom,
    output logic                            done,
    output logic [vpqv_pkg::H_W+FRAC_BITS-1:0] quot
);
    localparam int QW  = vpqv_pkg::H_W + FRAC_BITS;
    localparam int CW  = $clog2(QW + 1);

    logic [QW-1:0]               dvd_reg, dvd_next;
    logic [QW-1:0]               quot_reg, quot_next;
    logic [vpqv_pkg::H_W-1:0]    rem_reg, rem_next;
    logic [vpqv_pkg::H_W-1:0]    den_reg;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [vpqv_pkg::H_W:0]      rem_sh;
    logic [vpqv_pkg::H_W:0]      rem_sub;

    always_comb
    begin
        rem_sh    = {rem_reg, dvd_reg[QW-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = {numer, {FRAC_BITS{1'b0}}};
            quot_next = '0;
            rem_next  = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            if (!rem_sub[vpqv_pkg::H_W])
            begin
                rem_next  = rem_sub[vpqv_pkg::H_W-1:0];
                quot_next = {quot_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[vpqv_pkg::H_W-1:0];
                quot_next = {quot_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

### rtl/vertex_project_quad_visibility.sv
// Top level: camera projection of one vertex per request and shoelace face quality
// The divides are skipped when the divisor is zero; the next request is accepted only once
// the result has been registered to the output.
// One 32x32 multiplier serves 13 products in turn; one bit-serial divider gives both quotients.
// Input is accepted while a previous result still waits; a result not taken stalls the next.
// Reset (rst_n, async, low): camera registers to identity, face state cleared.
`timescale 1ns / 1ps
module vertex_project_quad_visibility #(
    parameter int FRAC_BITS = vpqv_pkg::VPQV_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // vertex_x, vertex_y, vertex_z
    input  logic [95:0]                        s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x, pixel_y, pixel_valid, divide_fault, face_inside, face_intersects,
    // face_quality, zero fill
    output logic [135:0]                       m_axis_tdata,
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vpqv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vpqv_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int QW = vpqv_pkg::H_W + FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_DIV_X, S_WAIT_X, S_DIV_Y, S_WAIT_Y, S_AMUL, S_AACC, S_FIN
    } state_t;

    state_t state_reg;

    logic [63:0] cam_reg [vpqv_pkg::CAM_REGS];
    logic [31:0] image_size_reg;
    logic [31:0] min_area_reg;

    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic               last_reg;
    logic [1:0]         row_reg, col_reg, ap_reg;
    logic signed [63:0] prod_reg, tmp_reg;
    logic signed [66:0] acc_reg;
    logic signed [63:0] hx_reg, hy_reg, hw_reg;
    logic               fault_reg;
    logic signed [31:0] px_reg, py_reg;

    logic signed [31:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [63:0] area_reg;
    logic [2:0]         cnt_reg;
    logic               all_reg, any_reg;

    logic               out_valid_reg;
    logic [135:0]       out_data_reg;
    logic               out_last_reg;

    logic               div_start, div_done;
    logic [63:0]        div_numer, div_denom;
    logic [QW-1:0]      div_quot;

    logic signed [31:0] mul_a, mul_b;
    logic [63:0]        cam_a, cam_b;
    logic signed [31:0] mcol;
    logic signed [66:0] acc_next;
    logic signed [63:0] h_next;
    logic signed [31:0] fx, fy;
    logic signed [64:0] term;
    logic signed [65:0] sum66;
    logic signed [63:0] area_next;
    logic               out_free;
    logic signed [63:0] area_fin;
    logic [2:0]         cnt_new;
    logic [62:0]        quality;
    logic               pix_valid;
    logic signed [63:0] xmax, ymax, half64;

    function automatic logic signed [31:0] proj(input logic [QW-1:0] q_in, input logic neg);
        logic [63:0]        qi;
        logic [63:0]        q;
        logic [63:0]        s;
        logic [64:0]        d;
        logic [31:0]        r;
        qi = q_in[QW-1:FRAC_BITS];
        q  = (qi > (64'd1 << 32)) ? (64'd1 << 56) : q_in[63:0];
        s  = neg ? (64'd0 - q) : q;
        d  = {s[63], s} - (65'd1 << (FRAC_BITS - 1));
        if (d[64:31] == {34{d[31]}})
        begin
            r = d[31:0];
        end
        else
        begin
            r = d[64] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    vpqv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        cam_a = cam_reg[{row_reg, 1'b0}];
        cam_b = cam_reg[{row_reg, 1'b1}];
        unique case (col_reg)
            2'd0:    mcol = cam_a[31:0];
            2'd1:    mcol = cam_a[63:32];
            default: mcol = cam_b[31:0];
        endcase
        fx = (cnt_reg == 3'd0) ? px_reg : first_x_reg;
        fy = (cnt_reg == 3'd0) ? py_reg : first_y_reg;
        if (state_reg == S_AMUL)
        begin
            unique case (ap_reg)
                2'd0:    begin mul_a = prev_x_reg; mul_b = py_reg; end
                2'd1:    begin mul_a = prev_y_reg; mul_b = px_reg; end
                2'd2:    begin mul_a = px_reg;     mul_b = fy;     end
                default: begin mul_a = py_reg;     mul_b = fx;     end
            endcase
        end
        else
        begin
            mul_a = mcol;
            unique case (col_reg)
                2'd0:    mul_b = vx_reg;
                2'd1:    mul_b = vy_reg;
                default: mul_b = vz_reg;
            endcase
        end
        acc_next = acc_reg + 67'(prod_reg);
        h_next   = 64'(acc_next >>> FRAC_BITS) + 64'(signed'(cam_b[63:32]));
        term     = 65'(tmp_reg) - 65'(prod_reg);
        sum66    = 66'(area_reg) + 66'(term);
        if (sum66[65:63] == {3{sum66[63]}})
        begin
            area_next = sum66[63:0];
        end
        else
        begin
            area_next = sum66[65] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        div_start = (state_reg == S_DIV_X && !fault_reg) || (state_reg == S_DIV_Y);
        div_numer = (state_reg == S_DIV_Y) ? (hy_reg[63] ? -hy_reg : hy_reg)
                                           : (hx_reg[63] ? -hx_reg : hx_reg);
        div_denom = hw_reg[63] ? -hw_reg : hw_reg;
        half64    = 64'sd1 <<< (FRAC_BITS - 1);
        xmax      = (64'(image_size_reg[15:0]) << FRAC_BITS) - half64;
        ymax      = (64'(image_size_reg[31:16]) << FRAC_BITS) - half64;
        pix_valid = !fault_reg && (64'(px_reg) >= -half64) && (64'(px_reg) <= xmax)
                    && (64'(py_reg) >= -half64) && (64'(py_reg) <= ymax);
        area_fin  = area_reg >>> 1;
        cnt_new   = (cnt_reg < 3'd7) ? cnt_reg + 3'd1 : cnt_reg;
        quality   = (last_reg && cnt_new == 3'd4 && !area_fin[63]
                     && area_fin >= 64'(min_area_reg)) ? area_fin[62:0] : 63'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cam_reg[0]     <= 64'd1 << FRAC_BITS;
            cam_reg[1]     <= '0;
            cam_reg[2]     <= 64'd1 << (32 + FRAC_BITS);
            cam_reg[3]     <= '0;
            cam_reg[4]     <= '0;
            cam_reg[5]     <= 64'd1 << FRAC_BITS;
            image_size_reg <= '0;
            min_area_reg   <= 32'd512;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            area_reg       <= '0;
            cnt_reg        <= '0;
            all_reg        <= 1'b1;
            any_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            ap_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == vpqv_pkg::CFG_IMAGE_SIZE)
                begin
                    image_size_reg <= cfg_data[31:0];
                end
                else if (cfg_index == vpqv_pkg::CFG_MIN_AREA)
                begin
                    min_area_reg <= cfg_data[31:0];
                end
                else
                begin
                    cam_reg[cfg_index] <= cfg_data;
                end
            end
            if (out_valid_reg && m_axis_tready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (col_reg == 2'd2)
                    begin
                        col_reg <= '0;
                        if (row_reg == 2'd2)
                        begin
                            state_reg <= S_DIV_X;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_DIV_X:
                begin
                    ap_reg    <= '0;
                    state_reg <= fault_reg ? S_AMUL : S_WAIT_X;
                end
                S_WAIT_X:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DIV_Y;
                    end
                end
                S_DIV_Y:
                begin
                    state_reg <= S_WAIT_Y;
                end
                S_WAIT_Y:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_AMUL;
                    end
                end
                S_AMUL:
                begin
                    state_reg <= S_AACC;
                end
                S_AACC:
                begin
                    if (ap_reg[0] && (ap_reg[1] ? last_reg : (cnt_reg != 3'd0)))
                    begin
                        area_reg <= area_next;
                    end
                    ap_reg    <= ap_reg + 2'd1;
                    state_reg <= (ap_reg == 2'd3) ? S_FIN : S_AMUL;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (last_reg)
                        begin
                            first_x_reg <= '0;
                            first_y_reg <= '0;
                            prev_x_reg  <= '0;
                            prev_y_reg  <= '0;
                            area_reg    <= '0;
                            cnt_reg     <= '0;
                            all_reg     <= 1'b1;
                            any_reg     <= 1'b0;
                        end
                        else
                        begin
                            if (cnt_reg == 3'd0)
                            begin
                                first_x_reg <= px_reg;
                                first_y_reg <= py_reg;
                            end
                            prev_x_reg <= px_reg;
                            prev_y_reg <= py_reg;
                            cnt_reg    <= cnt_new;
                            all_reg    <= all_reg && pix_valid;
                            any_reg    <= any_reg || pix_valid;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                vx_reg   <= signed'(s_axis_tdata[31:0]);
                vy_reg   <= signed'(s_axis_tdata[63:32]);
                vz_reg   <= signed'(s_axis_tdata[95:64]);
                last_reg <= s_axis_tlast;
                acc_reg  <= '0;
            end
            S_MUL, S_AMUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            S_ACC:
            begin
                if (col_reg == 2'd2)
                begin
                    acc_reg <= '0;
                    unique case (row_reg)
                        2'd0:    hx_reg <= h_next;
                        2'd1:    hy_reg <= h_next;
                        default:
                        begin
                            hw_reg    <= h_next;
                            fault_reg <= (h_next == 64'sd0);
                        end
                    endcase
                end
                else
                begin
                    acc_reg <= acc_next;
                end
            end
            S_DIV_X:
            begin
                if (fault_reg)
                begin
                    px_reg <= '0;
                    py_reg <= '0;
                end
            end
            S_WAIT_X:
            begin
                if (div_done)
                begin
                    px_reg <= proj(div_quot, hx_reg[63] ^ hw_reg[63]);
                end
            end
            S_WAIT_Y:
            begin
                if (div_done)
                begin
                    py_reg <= proj(div_quot, hy_reg[63] ^ hw_reg[63]);
                end
            end
            S_AACC:
            begin
                if (!ap_reg[0])
                begin
                    tmp_reg <= prod_reg;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_last_reg <= last_reg;
                    out_data_reg <= {5'd0, quality,
                                     last_reg && any_reg | (last_reg && pix_valid),
                                     last_reg && all_reg && pix_valid,
                                     fault_reg, pix_valid, py_reg, px_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[65] |-> m_axis_tdata[64:0] == 65'd0)
        else $error("fault result carries a pixel");
    a_quality_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[130:68] != 63'd0 |-> m_axis_tlast)
        else $error("quality outside face end");
    a_inside_any: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[66] |-> m_axis_tdata[67] && m_axis_tlast)
        else $error("inside without intersect");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");
endmodule

### test/vertex_project_quad_visibility_tb.sv
// Testbench: vertex projection and face quality checked against an in-bench projection model
`timescale 1ns / 1ps
module vertex_project_quad_visibility_tb;

    localparam int FB = vpqv_pkg::VPQV_FRAC_BITS;
    localparam longint HALF = longint'(1) << (FB - 1);
    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;
    localparam int SETTLE = 27 + 2 * (66 + FB) + 20;

    typedef struct packed {
        logic last;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } vertex_t;

    typedef struct packed {
        logic [62:0] quality;
        logic f_any;
        logic f_in;
        logic fault;
        logic valid;
        logic [31:0] py;
        logic [31:0] px;
        logic last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vpqv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vpqv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    vertex_project_quad_visibility u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // camera and face state of the projection model
    logic [63:0] cam [vpqv_pkg::CAM_REGS];
    logic [31:0] img_size, min_area_q;
    longint first_x, first_y, prev_x, prev_y, area_acc;
    int unsigned n_corners;
    bit all_in, any_in;

    vertex_t vertex_q[$];
    pixel_t pixel_q[$];
    bit in_taken = 1'b0;
    int send_idle = 6, recv_idle = 49;
    int mismatches = 0, n_results = 0, n_faces = 0, n_faults = 0;

    function automatic longint floor_sh(longint v);
        return v >>> FB;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        if (b > 0 && a > I64_MAX - b) return I64_MAX;
        if (b < 0 && a < I64_MIN - b) return I64_MIN;
        return a + b;
    endfunction

    function automatic longint cam_dot(int row, longint x, longint y, longint z);
        longint m0, m1, m2, m3, acc_hi, p;
        logic [63:0] acc_lo;
        m0 = longint'($signed(cam[2*row][31:0]));
        m1 = longint'($signed(cam[2*row][63:32]));
        m2 = longint'($signed(cam[2*row+1][31:0]));
        m3 = longint'($signed(cam[2*row+1][63:32]));
        acc_lo = 0;
        acc_hi = 0;
        p = m0 * x; acc_lo += p & ((64'd1 << FB) - 1); acc_hi += floor_sh(p);
        p = m1 * y; acc_lo += p & ((64'd1 << FB) - 1); acc_hi += floor_sh(p);
        p = m2 * z; acc_lo += p & ((64'd1 << FB) - 1); acc_hi += floor_sh(p);
        return acc_hi + longint'(acc_lo >> FB) + m3;
    endfunction

    function automatic longint div_pixel(longint n, longint d);
        logic [63:0] un, ud, qi, r, q;
        longint s;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        qi = un / ud;
        r = un % ud;
        if (qi > (64'd1 << 32)) q = 64'd1 << 56;
        else
        begin
            q = qi;
            for (int i = 0; i < FB; i++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= ud)
                begin
                    r -= ud;
                    q[0] = 1'b1;
                end
            end
        end
        s = ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
        s -= HALF;
        if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
        if (s < -64'sh8000_0000) s = -64'sh8000_0000;
        return s;
    endfunction

    function automatic pixel_t project_vertex(vertex_t v);
        pixel_t e;
        longint x, y, z, hx, hy, hw, px, py, xmax, ymax, area;
        x = longint'($signed(v.x));
        y = longint'($signed(v.y));
        z = longint'($signed(v.z));
        hx = cam_dot(0, x, y, z);
        hy = cam_dot(1, x, y, z);
        hw = cam_dot(2, x, y, z);
        e = '0;
        px = 0;
        py = 0;
        e.fault = (hw == 0);
        if (!e.fault)
        begin
            xmax = (longint'(img_size[15:0]) << FB) - HALF;
            ymax = (longint'(img_size[31:16]) << FB) - HALF;
            px = div_pixel(hx, hw);
            py = div_pixel(hy, hw);
            e.valid = px >= -HALF && px <= xmax && py >= -HALF && py <= ymax;
        end
        if (n_corners == 0)
        begin
            first_x = px;
            first_y = py;
        end
        else
            area_acc = sat_add(area_acc, prev_x * py - prev_y * px);
        prev_x = px;
        prev_y = py;
        if (n_corners < 7) n_corners++;
        if (!e.valid) all_in = 0;
        if (e.valid) any_in = 1;
        e.last = v.last;
        if (v.last)
        begin
            area_acc = sat_add(area_acc, px * first_y - py * first_x);
            area = area_acc >>> 1;
            if (n_corners == 4 && area >= 0 && area >= longint'(min_area_q))
                e.quality = area[62:0];
            e.f_in = all_in;
            e.f_any = any_in;
            first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
            area_acc = 0; n_corners = 0; all_in = 1; any_in = 0;
        end
        e.px = px[31:0];
        e.py = py[31:0];
        return e;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                in_taken = 1'b0;
                if (vertex_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    s_axis_tvalid <= 1'b1;
                    {s_axis_tlast, s_axis_tdata} <= vertex_q[0];
                    pixel_q.insert(pixel_q.size(), project_vertex(vertex_q.pop_front()));
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            in_taken = 1'b1;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '0;
            {got.px, got.py, got.valid, got.fault} = {m_axis_tdata[31:0],
                m_axis_tdata[63:32], m_axis_tdata[64], m_axis_tdata[65]};
            got.f_in = m_axis_tdata[66];
            got.f_any = m_axis_tdata[67];
            got.quality = m_axis_tdata[130:68];
            got.last = m_axis_tlast;
            n_results++;
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (want.fault) n_faults++;
                if (want.last) n_faces++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: px %h/%h py %h/%h v %b/%b f %b/%b l %b/%b in %b/%b any %b/%b q %h/%h",
                            want.px, got.px, want.py, got.py, want.valid, got.valid,
                            want.fault, got.fault, want.last, got.last, want.f_in, got.f_in,
                            want.f_any, got.f_any, want.quality, got.quality);
                end
            end
        end
    end

    task automatic write_reg(input logic [vpqv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx < vpqv_pkg::CAM_REGS) cam[idx] = val;
        else if (idx == vpqv_pkg::CFG_IMAGE_SIZE) img_size = val[31:0];
        else min_area_q = val[31:0];
    endtask

    task automatic drain();
        while (vertex_q.size() > 0 || pixel_q.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] fx(int v);
        return 32'(v) << FB;
    endfunction

    task automatic push_face(int corners, bit wide);
        vertex_t v;
        int cx, cy, r;
        cx = $urandom_range(40);
        cy = $urandom_range(40);
        r = $urandom_range(1, 20);
        for (int i = 0; i < corners; i++)
        begin
            v.x = wide ? $urandom : fx(cx + ((i == 1 || i == 2) ? r : 0)) + $urandom_range(65535);
            v.y = wide ? $urandom : fx(cy + ((i >= 2) ? r : 0)) + $urandom_range(65535);
            v.z = wide ? $urandom : fx($urandom_range(1, 3));
            if ($urandom_range(9) == 0) v.z = $urandom;
            v.last = (i == corners - 1);
            vertex_q.insert(vertex_q.size(), v);
        end
    endtask

    task automatic random_phase(int n);
        int k;
        k = 0;
        while (k < n)
        begin
            case ($urandom_range(9))
                0: begin push_face($urandom_range(1, 7), 1'b1); k += 4; end
                1: begin push_face($urandom_range(1, 9), 1'b0); k += 5; end
                default: begin push_face(4, 1'b0); k += 4; end
            endcase
        end
    endtask

    task automatic random_camera();
        for (int r = 0; r < 3; r++)
        begin
            cam[2*r] = {fx(r == 1) + 32'($urandom_range(8191)), fx(r == 0)
                + 32'($urandom_range(8191))};
            cam[2*r+1] = {32'($urandom_range(3)) << FB, fx(r == 2)};
        end
        for (int i = 0; i < vpqv_pkg::CAM_REGS; i++)
            write_reg(i[vpqv_pkg::CFG_IDX_W-1:0], cam[i]);
    endtask

    initial
    begin
        vertex_t v;
        cam[0] = 64'd1 << FB; cam[1] = 0; cam[2] = 64'd1 << (32 + FB);
        cam[3] = 0; cam[4] = 0; cam[5] = 64'd1 << FB;
        img_size = 0; min_area_q = 512;
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        area_acc = 0; n_corners = 0; all_in = 1; any_in = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed: default camera with zero image, then bounds and faults
        push_face(4, 1'b0);
        drain();
        write_reg(vpqv_pkg::CFG_IMAGE_SIZE, {32'h0, 16'd64, 16'd64});
        write_reg(vpqv_pkg::CFG_MIN_AREA, 64'd0);
        push_face(4, 1'b0);
        push_face(4, 1'b0);
        v = '{last: 1'b0, x: 32'h7FFF_FFFF, y: 32'h8000_0000, z: 32'h0};
        vertex_q.insert(vertex_q.size(), v);
        v = '{last: 1'b0, x: 32'h8000_0000, y: 32'h7FFF_FFFF, z: 32'hFFFF_FFFF};
        vertex_q.insert(vertex_q.size(), v);
        v = '{last: 1'b0, x: 32'hFFFF_FFFF, y: 32'h0, z: 32'h0000_0001};
        vertex_q.insert(vertex_q.size(), v);
        v = '{last: 1'b1, x: 32'h0, y: 32'h0, z: 32'h8000_0000};
        vertex_q.insert(vertex_q.size(), v);
        v = '{last: 1'b1, x: fx(3), y: fx(3), z: fx(1)};
        vertex_q.insert(vertex_q.size(), v);
        push_face(3, 1'b0);
        push_face(5, 1'b0);
        drain();
        write_reg(vpqv_pkg::CFG_CAM_ROW2_A, {fx(0), fx(0)});
        write_reg(vpqv_pkg::CFG_CAM_ROW2_B, {fx(0), fx(0)});
        push_face(2, 1'b0);
        drain();
        write_reg(vpqv_pkg::CFG_IMAGE_SIZE, 64'hFFFF_FFFF);
        write_reg(vpqv_pkg::CFG_MIN_AREA, 64'hFFFF_FFFF);
        random_camera();
        random_phase(200);
        drain();
        send_idle = 49;
        recv_idle = 6;
        write_reg(vpqv_pkg::CFG_IMAGE_SIZE, {32'h0, 16'd48, 16'd48});
        write_reg(vpqv_pkg::CFG_MIN_AREA, 64'd1 << 32);
        random_camera();
        random_phase(200);
        drain();
        send_idle = 0;
        recv_idle = 0;
        write_reg(vpqv_pkg::CFG_MIN_AREA, 64'd0);
        random_phase(200);
        drain();
        $display("covered %0d results, %0d faces, %0d divide faults", n_results, n_faces,
            n_faults);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("vertex_project_quad_visibility_tb: PASS");
        else
            $display("vertex_project_quad_visibility_tb: FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("vertex_project_quad_visibility_tb: FAIL");
        $finish;
    end
endmodule
